// File: hw/rtl/spm_pkg.sv
package spm_pkg;

  // Sizes of the machine; both depths are powers of two
  localparam int STACK_DEPTH = 1024;
  localparam int CODE_DEPTH  = 1024;
  localparam int WORD_BITS   = 32;

  localparam int AW = $clog2(STACK_DEPTH);   // stack address bits
  localparam int TW = AW + 1;                // top index, holds STACK_DEPTH itself
  localparam int CW = $clog2(CODE_DEPTH);    // code address bits

  localparam int LINK_WORDS = 3;              // static link, dynamic link, return address

  // Function codes
  localparam logic [3:0] OP_LIT = 4'd0;
  localparam logic [3:0] OP_OPR = 4'd1;
  localparam logic [3:0] OP_LOD = 4'd2;
  localparam logic [3:0] OP_STO = 4'd3;
  localparam logic [3:0] OP_CAL = 4'd4;
  localparam logic [3:0] OP_INT = 4'd5;
  localparam logic [3:0] OP_JMP = 4'd6;
  localparam logic [3:0] OP_JPC = 4'd7;
  localparam logic [3:0] OP_RED = 4'd8;
  localparam logic [3:0] OP_WRT = 4'd9;

  // opr sub-codes
  localparam logic [4:0] SUB_RET = 5'd0;
  localparam logic [4:0] SUB_NEG = 5'd1;
  localparam logic [4:0] SUB_ADD = 5'd2;
  localparam logic [4:0] SUB_SUB = 5'd3;
  localparam logic [4:0] SUB_MUL = 5'd4;
  localparam logic [4:0] SUB_DIV = 5'd5;
  localparam logic [4:0] SUB_ODD = 5'd6;
  localparam logic [4:0] SUB_PAR = 5'd7;
  localparam logic [4:0] SUB_EQ  = 5'd8;
  localparam logic [4:0] SUB_NE  = 5'd9;
  localparam logic [4:0] SUB_LT  = 5'd10;
  localparam logic [4:0] SUB_GE  = 5'd11;
  localparam logic [4:0] SUB_GT  = 5'd12;
  localparam logic [4:0] SUB_LE  = 5'd13;
  localparam logic [4:0] SUB_PRN = 5'd14;
  localparam logic [4:0] SUB_NL  = 5'd15;
  localparam logic [4:0] SUB_RD  = 5'd16;

  // Print kinds
  localparam logic [1:0] PK_NONE  = 2'd0;
  localparam logic [1:0] PK_VAL   = 2'd1;
  localparam logic [1:0] PK_VALNL = 2'd2;
  localparam logic [1:0] PK_NL    = 2'd3;

  // Fault codes
  localparam logic [1:0] FLT_NONE = 2'd0;
  localparam logic [1:0] FLT_OVF  = 2'd1;
  localparam logic [1:0] FLT_DIV0 = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_WALKW,
    ST_ADDR,
    ST_RD2,
    ST_EXEC,
    ST_DIV,
    ST_DFIX,
    ST_WR,
    ST_FIN
  } state_t;

endpackage

// File: hw/rtl/stack_pcode_machine_unit.sv
// Stack p-code machine: executes one instruction per transfer on the command
// channel and gives one result transfer for it. All machine state except the
// registers top, frame base, program counter, parameter slot and stop flag
// lives in one single-port-read, single-port-write stack RAM with a registered
// read, so an instruction runs as a short sequence of steps: the command
// transfer, a walk step plus a wait and a walk step per level of level_diff
// for the static-link walk (lod, sto, cal, red only), two read steps, an
// execute step, one step per stack write (up to three, for cal) and a step to
// hand over the result. A division adds 32 quotient steps of a
// one-bit-per-cycle restoring divider, a sign fix and the quotient write.
// The hand-over waits while the output register still holds a result that
// has not been taken. The next command is taken once the result has moved
// into the output register. No clearing pass is needed after reset.
module stack_pcode_machine_unit
  import spm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // command channel
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  logic [3:0]           operation,
  input  logic [3:0]           level_diff,
  input  logic signed [31:0]   operand,
  input  logic signed [31:0]   read_value,
  // result channel
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [9:0]           next_pc,
  output logic [1:0]           print_kind,
  output logic signed [31:0]   print_value,
  output logic                 read_taken,
  output logic                 halted,
  output logic [1:0]           fault
);

  typedef logic [WORD_BITS-1:0] word_t;

  state_t state, state_next;

  // architectural registers
  logic [TW-1:0] top;
  logic [AW-1:0] fb;
  logic [CW-1:0] pc;
  logic [TW-1:0] ps;
  logic          stopped;

  // latched command
  logic [3:0] op;
  word_t      opnd;
  word_t      rval;

  // static-link walk
  logic [AW-1:0] cur;
  logic [3:0]    hops;

  // stack RAM
  word_t         mem [STACK_DEPTH];
  logic [AW-1:0] mem_ra, mem_wa;
  word_t         mem_wd, rd_q, rd_data, opa;
  logic          mem_we, rd_zero;
  logic [2:0]    low_ok;

  // pending writes
  logic [AW-1:0] wa [3];
  word_t         wd [3];
  logic [1:0]    nw, widx;

  // divider
  word_t          dq, dy;
  logic [WORD_BITS:0] drem;
  logic [$clog2(WORD_BITS)-1:0] dcnt;
  logic           dneg;
  logic [AW-1:0]  dwa;

  // pending result
  logic [CW-1:0] r_pc;
  logic [1:0]    r_kind, r_fault;
  word_t         r_pv;
  logic          r_taken, r_halt;

  // decode helpers
  logic          sub_ok;
  logic [4:0]    sub;
  logic [TW-1:0] td;
  logic [AW-1:0] ra1, ra2;
  logic [CW-1:0] pc_inc;
  logic          ovf_in;

  assign sub_ok = (opnd[WORD_BITS-1:5] == '0);
  assign sub    = opnd[4:0];
  assign td     = (top != '0) ? top - TW'(1) : top;
  assign pc_inc = pc + CW'(1);
  assign ovf_in = top[TW-1];

  // read addresses, from the latched command and the walk result
  always_comb begin
    ra1 = td[AW-1:0];
    ra2 = td[AW-1:0] - AW'(1);
    unique case (op)
      OP_OPR: begin
        if (sub_ok && sub == SUB_RET) begin
          ra1 = fb + AW'(2);
          ra2 = fb + AW'(1);
        end else if (sub_ok && (sub == SUB_NEG || sub == SUB_ODD)) begin
          ra1 = top[AW-1:0] - AW'(1);
        end
      end
      OP_LOD:  ra1 = cur + opnd[AW-1:0];
      default: ra1 = td[AW-1:0];
    endcase
  end

  // execute step
  logic [TW-1:0] ex_top, ex_ps;
  logic [AW-1:0] ex_fb;
  logic [CW-1:0] ex_pc;
  logic [1:0]    ex_kind, ex_fault, ex_nw;
  word_t         ex_pv, x, y, ex_bin;
  logic          ex_taken, ex_div;
  logic [AW-1:0] ex_wa [3];
  word_t         ex_wd [3];
  logic signed [WORD_BITS+1:0] nt;
  logic [TW:0]   sum_ps, sum_cal;
  logic [AW-1:0] st_adr;

  assign y       = opa;
  assign x       = rd_data;
  assign sum_ps  = {1'b0, top} + {1'b0, ps};
  assign sum_cal = {1'b0, top} + (TW+1)'(2);
  assign st_adr  = cur + opnd[AW-1:0];
  assign nt      = $signed({{(WORD_BITS+2-TW){1'b0}}, top})
                 + $signed({{2{opnd[WORD_BITS-1]}}, opnd});

  // binary operator on the two top words
  always_comb begin
    unique case (sub)
      SUB_ADD: ex_bin = x + y;
      SUB_SUB: ex_bin = x - y;
      SUB_MUL: ex_bin = x * y;
      SUB_EQ:  ex_bin = word_t'(x == y);
      SUB_NE:  ex_bin = word_t'(x != y);
      SUB_LT:  ex_bin = word_t'($signed(x) < $signed(y));
      SUB_GE:  ex_bin = word_t'(!($signed(x) < $signed(y)));
      SUB_GT:  ex_bin = word_t'($signed(y) < $signed(x));
      default: ex_bin = word_t'(!($signed(y) < $signed(x)));
    endcase
  end

  always_comb begin
    ex_top   = top;
    ex_fb    = fb;
    ex_pc    = pc_inc;
    ex_ps    = ps;
    ex_kind  = PK_NONE;
    ex_pv    = '0;
    ex_taken = 1'b0;
    ex_fault = FLT_NONE;
    ex_nw    = 2'd0;
    ex_div   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ex_wa[i] = top[AW-1:0];
      ex_wd[i] = '0;
    end
    if (ovf_in) begin
      ex_fault = FLT_OVF;
    end else begin
      unique case (op)
        OP_LIT: begin
          ex_nw = 2'd1; ex_wd[0] = opnd; ex_top = top + TW'(1);
        end
        OP_OPR: begin
          if (sub_ok) begin
            unique case (sub)
              SUB_RET: begin
                ex_pc  = opa[CW-1:0];
                ex_fb  = rd_data[AW-1:0];
                ex_top = {1'b0, fb};
              end
              SUB_NEG: begin
                ex_nw = 2'd1; ex_wa[0] = ra1; ex_wd[0] = '0 - opa;
              end
              SUB_ODD: begin
                ex_nw = 2'd1; ex_wa[0] = ra1; ex_wd[0] = opa & word_t'(1);
              end
              SUB_ADD, SUB_SUB, SUB_MUL, SUB_EQ, SUB_NE,
              SUB_LT, SUB_GE, SUB_GT, SUB_LE: begin
                ex_top = td; ex_nw = 2'd1; ex_wa[0] = ra2; ex_wd[0] = ex_bin;
              end
              SUB_DIV: begin
                ex_top = td;
                if (opa == '0) ex_fault = FLT_DIV0;
                else ex_div = 1'b1;
              end
              SUB_PAR: begin
                if (sum_ps >= (TW+1)'(STACK_DEPTH)) begin
                  ex_fault = FLT_OVF;
                end else begin
                  ex_top = td; ex_ps = ps + TW'(1); ex_nw = 2'd1;
                  ex_wa[0] = td[AW-1:0] + ps[AW-1:0]; ex_wd[0] = opa;
                end
              end
              SUB_PRN: begin
                ex_top = td; ex_kind = PK_VALNL; ex_pv = opa;
              end
              SUB_NL: ex_kind = PK_NL;
              SUB_RD: begin
                ex_nw = 2'd1; ex_wd[0] = rval; ex_top = top + TW'(1); ex_taken = 1'b1;
              end
              default: ;
            endcase
          end
        end
        OP_LOD: begin
          ex_nw = 2'd1; ex_wd[0] = opa; ex_top = top + TW'(1);
        end
        OP_STO: begin
          ex_top = td; ex_nw = 2'd1; ex_wa[0] = st_adr; ex_wd[0] = opa;
        end
        OP_CAL: begin
          if (sum_cal >= (TW+1)'(STACK_DEPTH)) begin
            ex_fault = FLT_OVF;
          end else begin
            ex_nw    = 2'd3;
            ex_wa[1] = top[AW-1:0] + AW'(1);
            ex_wa[2] = top[AW-1:0] + AW'(2);
            ex_wd[0] = word_t'(cur);
            ex_wd[1] = word_t'(fb);
            ex_wd[2] = word_t'(pc_inc);
            ex_fb    = top[AW-1:0];
            ex_pc    = opnd[CW-1:0];
            ex_ps    = TW'(LINK_WORDS);
          end
        end
        OP_INT: begin
          if (nt < 0) ex_top = '0;
          else if (nt > (WORD_BITS+2)'(STACK_DEPTH)) ex_top = TW'(STACK_DEPTH);
          else ex_top = nt[TW-1:0];
        end
        OP_JMP: ex_pc = opnd[CW-1:0];
        OP_JPC: begin
          ex_top = td;
          if (opa == '0) ex_pc = opnd[CW-1:0];
        end
        OP_RED: begin
          ex_nw = 2'd2; ex_wd[0] = rval; ex_wa[1] = st_adr; ex_wd[1] = rval;
          ex_taken = 1'b1;
        end
        OP_WRT: begin
          ex_top = td; ex_kind = PK_VAL; ex_pv = opa;
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (cmd_valid) state_next = ST_WALK;
      ST_WALK:  state_next = (hops == '0) ? ST_ADDR : ST_WALKW;
      ST_WALKW: state_next = ST_WALK;
      ST_ADDR:  state_next = ST_RD2;
      ST_RD2:   state_next = ST_EXEC;
      ST_EXEC: begin
        if (stopped) state_next = ST_FIN;
        else if (ex_div) state_next = ST_DIV;
        else if (ex_nw != 2'd0) state_next = ST_WR;
        else state_next = ST_FIN;
      end
      ST_DIV:   if (dcnt == ($clog2(WORD_BITS))'(WORD_BITS-1)) state_next = ST_DFIX;
      ST_DFIX:  state_next = ST_WR;
      ST_WR:    if (widx == nw - 2'd1) state_next = ST_FIN;
      ST_FIN:   if (!res_valid || !res_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_stall = (state != ST_IDLE);
    mem_we    = (state == ST_WR);
    mem_wa    = wa[widx];
    mem_wd    = wd[widx];
    unique case (state)
      ST_WALK: mem_ra = cur;
      ST_RD2:  mem_ra = ra2;
      default: mem_ra = ra1;
    endcase
  end

  // stack RAM; words 0 to 2 read as zero until first written
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q    <= mem[mem_ra];
    rd_zero <= (mem_ra < AW'(3)) && !low_ok[mem_ra[1:0]];
  end
  assign rd_data = rd_zero ? '0 : rd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_ok <= '0;
    end else if (mem_we && mem_wa < AW'(3)) begin
      low_ok[mem_wa[1:0]] <= 1'b1;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      top       <= '0;
      fb        <= '0;
      pc        <= '0;
      ps        <= TW'(LINK_WORDS);
      stopped   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FIN && (!res_valid || !res_stall)) res_valid <= 1'b1;
      else if (res_valid && !res_stall) res_valid <= 1'b0;
      if (state == ST_EXEC && !stopped) begin
        top <= ex_top;
        fb  <= ex_fb;
        pc  <= ex_pc;
        ps  <= ex_ps;
        if (ex_fault != FLT_NONE || ex_pc == '0) stopped <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        op   <= operation;
        opnd <= operand;
        rval <= read_value;
        cur  <= fb;
        hops <= (!stopped && !ovf_in && (operation == OP_LOD || operation == OP_STO ||
                 operation == OP_CAL || operation == OP_RED)) ? level_diff : 4'd0;
      end
      ST_WALKW: begin
        cur  <= rd_data[AW-1:0];
        hops <= hops - 4'd1;
      end
      ST_RD2: opa <= rd_data;
      ST_EXEC: begin
        widx <= 2'd0;
        nw   <= ex_nw;
        for (int i = 0; i < 3; i++) begin
          wa[i] <= ex_wa[i];
          wd[i] <= ex_wd[i];
        end
        if (stopped) begin
          r_pc <= pc; r_kind <= PK_NONE; r_pv <= '0;
          r_taken <= 1'b0; r_halt <= 1'b1; r_fault <= FLT_NONE;
        end else begin
          r_pc <= ex_pc; r_kind <= ex_kind; r_pv <= ex_pv; r_taken <= ex_taken;
          r_halt <= (ex_fault != FLT_NONE) || (ex_pc == '0); r_fault <= ex_fault;
        end
        // divider set-up on magnitudes
        dq   <= rd_data[WORD_BITS-1] ? '0 - rd_data : rd_data;
        dy   <= opa[WORD_BITS-1] ? '0 - opa : opa;
        dneg <= rd_data[WORD_BITS-1] ^ opa[WORD_BITS-1];
        drem <= '0;
        dcnt <= '0;
        dwa  <= ra2;
      end
      ST_DIV: begin
        // one quotient bit per cycle
        if ({drem[WORD_BITS-1:0], dq[WORD_BITS-1]} >= {1'b0, dy}) begin
          drem <= {drem[WORD_BITS-1:0], dq[WORD_BITS-1]} - {1'b0, dy};
          dq   <= {dq[WORD_BITS-2:0], 1'b1};
        end else begin
          drem <= {drem[WORD_BITS-1:0], dq[WORD_BITS-1]};
          dq   <= {dq[WORD_BITS-2:0], 1'b0};
        end
        dcnt <= dcnt + 1'b1;
      end
      ST_DFIX: begin
        nw    <= 2'd1;
        wa[0] <= dwa;
        wd[0] <= dneg ? '0 - dq : dq;
      end
      ST_WR: widx <= widx + 2'd1;
      ST_FIN: begin
        if (!res_valid || !res_stall) begin
          next_pc     <= r_pc;
          print_kind  <= r_kind;
          print_value <= r_pv;
          read_taken  <= r_taken;
          halted      <= r_halt;
          fault       <= r_fault;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    res_valid && (fault != FLT_NONE) |-> halted)
    else $error("fault reported without halt");

  a_top_range: assert property (@(posedge clk) disable iff (rst)
    top <= TW'(STACK_DEPTH))
    else $error("top index beyond stack depth");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("machine restarted after stop");

  a_read_no_print: assert property (@(posedge clk) disable iff (rst)
    res_valid && read_taken |-> (print_kind == PK_NONE))
    else $error("read and print in one instruction");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("second command taken before first finished");

endmodule
